// ----- sv/lpp_pkg.sv -----
package lpp_pkg;

  localparam int NUM_LEDS_DEFAULT = 4;
  localparam int NUM_LEDS_MAX = 16;
  localparam int LEVELS_W = 4;

  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_ON      = 3'd1;
  localparam logic [2:0] MODE_RUNNING = 3'd2;
  localparam logic [2:0] MODE_PAUSE   = 3'd3;
  localparam logic [2:0] MODE_ALARM   = 3'd4;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  localparam logic [7:0] RUN_PERIOD      = 8'd128;
  localparam logic [4:0] RUN_DIVIDE      = 5'd8;
  localparam logic [4:0] ALARM_DIVIDE    = 5'd2;
  localparam logic [4:0] ALARM_TABLE_LEN = 5'd16;
  localparam logic [4:0] PAUSE_PRESCALE  = 5'd31;
  localparam logic [7:0] PAUSE_ON_SHORT  = 8'd20;
  localparam logic [7:0] PAUSE_OFF_SHORT = 8'd50;
  localparam logic [7:0] PAUSE_OFF_LONG  = 8'd250;

  localparam logic [4:0] PHASE_FIRST_ON   = 5'd0;
  localparam logic [4:0] PHASE_SHORT_OFF  = 5'd1;
  localparam logic [4:0] PHASE_SECOND_ON  = 5'd2;
  localparam logic [4:0] PHASE_LONG_OFF   = 5'd3;

  localparam logic [7:0] ALARM_TABLE [16] = '{
    8'd0, 8'd9, 8'd37, 8'd79, 8'd128, 8'd176, 8'd218, 8'd246,
    8'd255, 8'd246, 8'd218, 8'd176, 8'd128, 8'd79, 8'd37, 8'd9
  };

  localparam logic [7:0] RUN_TABLE [32] = '{
    8'd0, 8'd1, 8'd6, 8'd15, 8'd26, 8'd39, 8'd54, 8'd70,
    8'd85, 8'd100, 8'd113, 8'd124, 8'd133, 8'd138, 8'd140, 8'd138,
    8'd133, 8'd124, 8'd113, 8'd100, 8'd85, 8'd70, 8'd54, 8'd39,
    8'd26, 8'd15, 8'd6, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0
  };

  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] step;
    logic [7:0] period;
    logic [4:0] slow;
    logic       pin;
  } led_state_t;

endpackage

// ----- sv/lpp_if.sv -----
interface lpp_req_if;
  import lpp_pkg::*;

  logic       valid;
  logic       ready;
  logic       operation;
  logic [1:0] led_index;
  logic [2:0] new_mode;

  modport source (output valid, output operation, output led_index, output new_mode,
                  input ready);
  modport sink (input valid, input operation, input led_index, input new_mode,
                output ready);
endinterface

interface lpp_rsp_if;
  import lpp_pkg::*;

  logic                valid;
  logic                ready;
  logic [LEVELS_W-1:0] led_levels;

  modport source (output valid, output led_levels, input ready);
  modport sink (input valid, input led_levels, output ready);
endinterface

// ----- sv/lpp_update.sv -----
module lpp_update (
  input  lpp_pkg::led_state_t cur,
  output lpp_pkg::led_state_t nxt
);
  import lpp_pkg::*;

  logic [7:0] period_inc;
  logic [4:0] slow_inc;
  logic [4:0] step_inc;
  logic [7:0] limit;
  logic       next_level;
  logic       phase_ok;

  assign period_inc = cur.period + 8'd1;
  assign slow_inc   = cur.slow + 5'd1;
  assign step_inc   = cur.step + 5'd1;

  always_comb begin
    limit      = PAUSE_ON_SHORT;
    next_level = 1'b0;
    phase_ok   = 1'b1;
    case (cur.step)
      PHASE_FIRST_ON: begin
        limit      = PAUSE_ON_SHORT;
        next_level = 1'b0;
      end
      PHASE_SHORT_OFF: begin
        limit      = PAUSE_OFF_SHORT;
        next_level = 1'b1;
      end
      PHASE_SECOND_ON: begin
        limit      = PAUSE_ON_SHORT;
        next_level = 1'b0;
      end
      PHASE_LONG_OFF: begin
        limit      = PAUSE_OFF_LONG;
        next_level = 1'b1;
      end
      default: begin
        phase_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    nxt = cur;
    unique case (cur.mode)
      MODE_RUNNING: begin
        nxt.period = period_inc;
        nxt.pin    = (period_inc < RUN_TABLE[cur.step]);
        if (period_inc == RUN_PERIOD) begin
          nxt.period = '0;
          nxt.slow   = slow_inc;
          if (slow_inc == RUN_DIVIDE) begin
            nxt.slow = '0;
            nxt.step = step_inc;
          end
        end
      end
      MODE_ALARM: begin
        nxt.period = period_inc;
        nxt.pin    = (period_inc < ALARM_TABLE[cur.step[3:0]]);
        if (period_inc == 8'd0) begin
          nxt.slow = slow_inc;
          if (slow_inc == ALARM_DIVIDE) begin
            nxt.slow = '0;
            nxt.step = (step_inc == ALARM_TABLE_LEN) ? 5'd0 : step_inc;
          end
        end
      end
      MODE_PAUSE: begin
        if (slow_inc != PAUSE_PRESCALE) begin
          nxt.slow = slow_inc;
        end else begin
          nxt.slow = '0;
          if (!phase_ok) begin
            nxt.period = '0;
            nxt.step   = '0;
            nxt.pin    = 1'b0;
          end else if (period_inc == limit) begin
            nxt.period = '0;
            nxt.step   = {3'd0, step_inc[1:0]};
            nxt.pin    = next_level;
          end else begin
            nxt.period = period_inc;
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ----- sv/led_pattern_pwm_controller.sv -----
// Drives NUM_LEDS LED pins in off, on, running (breathing PWM), pause (double blink) or
// alarm mode. Each request word is either a mode command for one LED or a PWM tick for
// all LEDs, and each request yields one response word with the pin levels of LEDs 0 to 3.
// A tick walks the LEDs through one shared update unit, one LED per cycle, and the block
// takes a new request only once the response to the last one has been loaded into the
// output register. The response sits in that output register, so a new request can be
// taken while the previous response still waits.
module led_pattern_pwm_controller #(
  parameter int NUM_LEDS = lpp_pkg::NUM_LEDS_DEFAULT
) (
  input logic     clk,
  input logic     rst,
  lpp_req_if.sink   req,
  lpp_rsp_if.source rsp
);
  import lpp_pkg::*;

  localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEDS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state;
  logic [IDX_W-1:0] seq_idx;

  logic [2:0] mode   [NUM_LEDS];
  logic [4:0] step   [NUM_LEDS];
  logic [7:0] period [NUM_LEDS];
  logic [4:0] slow   [NUM_LEDS];
  logic       pin    [NUM_LEDS];

  logic                out_valid;
  logic [LEVELS_W-1:0] out_levels;
  logic [LEVELS_W-1:0] levels;

  led_state_t cur;
  led_state_t nxt;

  logic             accept;
  logic [4:0]       cmd_wide;
  logic             cmd_ok;
  logic [IDX_W-1:0] cmd_idx;
  logic             load_out;

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign cmd_wide   = {3'd0, req.led_index};
  assign cmd_ok     = (cmd_wide < 5'(NUM_LEDS)) && (req.new_mode <= MODE_ALARM);
  assign cmd_idx    = cmd_wide[IDX_W-1:0];
  assign load_out   = (state == S_DONE) && (!out_valid || rsp.ready);

  assign rsp.valid      = out_valid;
  assign rsp.led_levels = out_levels;

  assign cur.mode   = mode[seq_idx];
  assign cur.step   = step[seq_idx];
  assign cur.period = period[seq_idx];
  assign cur.slow   = slow[seq_idx];
  assign cur.pin    = pin[seq_idx];

  lpp_update u_update (
    .cur (cur),
    .nxt (nxt)
  );

  for (genvar g = 0; g < LEVELS_W; g++) begin : g_levels
    if (g < NUM_LEDS) begin : g_live
      assign levels[g] = pin[g];
    end else begin : g_dark
      assign levels[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      seq_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          seq_idx <= '0;
          if (accept) begin
            state <= (req.operation == OP_TICK) ? S_RUN : S_DONE;
          end
        end
        S_RUN: begin
          if (seq_idx == LAST_IDX) begin
            state   <= S_DONE;
            seq_idx <= '0;
          end else begin
            seq_idx <= seq_idx + 1'b1;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        mode[i]   <= MODE_OFF;
        step[i]   <= '0;
        period[i] <= '0;
        slow[i]   <= '0;
        pin[i]    <= 1'b0;
      end
    end else if (state == S_RUN) begin
      step[seq_idx]   <= nxt.step;
      period[seq_idx] <= nxt.period;
      slow[seq_idx]   <= nxt.slow;
      pin[seq_idx]    <= nxt.pin;
    end else if (accept && (req.operation == OP_SET) && cmd_ok) begin
      mode[cmd_idx] <= req.new_mode;
      unique case (req.new_mode)
        MODE_OFF: begin
          pin[cmd_idx] <= 1'b0;
        end
        MODE_ON, MODE_PAUSE: begin
          pin[cmd_idx] <= 1'b1;
        end
        default: begin
          step[cmd_idx]   <= '0;
          period[cmd_idx] <= '0;
          slow[cmd_idx]   <= '0;
          pin[cmd_idx]    <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_levels <= levels;
    end
  end

endmodule

// ----- sv/lpp_checker.sv -----
module lpp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_levels
);

  // Each accepted word keeps the block busy in the cycle after it is taken.
  assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> !in_ready)
    else $error("request taken on two consecutive cycles");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("response valid right after reset");

  assert property (@(posedge clk) rst |=> in_ready)
    else $error("block not ready right after reset");

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("response dropped before it was taken");

  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !out_ready |=> $stable(out_levels))
    else $error("stalled response changed");

endmodule

bind led_pattern_pwm_controller lpp_checker u_lpp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_levels (rsp.led_levels)
);
